[design/nvmeqp_pkg.sv]
package nvmeqp_pkg;

    localparam int QUEUE_DEPTH = 8;
    localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
    localparam int PAGE_BYTES  = 4096;
    localparam int CHUNK_BYTES = 2 * PAGE_BYTES;
    localparam int CHUNK_W     = $clog2(CHUNK_BYTES) + 1;

    localparam int LBA_W    = 64;
    localparam int COUNT_W  = 32;
    localparam int CID_W    = 16;
    localparam int NLB_W    = 16;
    localparam int STATUS_W = 15;
    localparam int CFG_W    = 32;

    localparam logic [4:0] BS_LOG2_MIN   = 5'd9;
    localparam logic [4:0] BS_LOG2_MAX   = 5'd20;
    localparam logic [4:0] BS_LOG2_RESET = 5'd9;

    localparam logic CFG_BLOCK_SIZE_LOG2 = 1'b0;
    localparam logic CFG_NAMESPACE_ID    = 1'b1;

    localparam logic [1:0] REQ_RW    = 2'd0;
    localparam logic [1:0] REQ_FLUSH = 2'd1;
    localparam logic [1:0] REQ_CQE   = 2'd2;

    localparam logic KIND_CMD  = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    localparam logic [1:0] OPC_FLUSH = 2'd0;
    localparam logic [1:0] OPC_WRITE = 2'd1;
    localparam logic [1:0] OPC_READ  = 2'd2;

    localparam logic [2:0] ERR_OK        = 3'd0;
    localparam logic [2:0] ERR_ZERO      = 3'd1;
    localparam logic [2:0] ERR_ID        = 3'd2;
    localparam logic [2:0] ERR_DEVICE    = 3'd3;
    localparam logic [2:0] ERR_TOO_LARGE = 3'd4;
    localparam logic [2:0] ERR_BUSY      = 3'd5;

endpackage

[design/nvme_queue_pair_command_engine.sv]
// Host-side command engine for one NVMe submission/completion queue pair.
// The s_ channel carries one word per event: a read/write request, a flush
// request, or the completion entry currently seen at the completion head.
// The m_ channel carries one word per issued command or finished request;
// events that cause nothing (stale phase, completion while idle, unknown
// type) are accepted and produce no word.
// A read/write request is split into chunks of at most two pages; the first
// chunk is issued at once and each good completion issues the next one.
// The result of an accepted word is registered in the single output register,
// and one word is accepted every cycle while that register is free or being
// emptied in the same cycle. While the receiver stalls with a word held in
// the output register, the engine accepts nothing.
// Reset (aresetn low at a clock edge) clears the queue pointers, sets the
// expected phase and next command id to one, and sets the block size to
// 512 bytes. Configuration writes take effect at the next edge and should
// only be made while no request is in flight.
module nvme_queue_pair_command_engine (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                cfg_wr_en,
    input  logic                                cfg_addr,
    input  logic [nvmeqp_pkg::CFG_W-1:0]        cfg_wdata,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          s_req_type,
    input  logic                                s_write_op,
    input  logic [nvmeqp_pkg::LBA_W-1:0]        s_start_lba,
    input  logic [nvmeqp_pkg::COUNT_W-1:0]      s_block_count,
    input  logic                                s_cqe_phase,
    input  logic [nvmeqp_pkg::STATUS_W-1:0]     s_cqe_status_field,
    input  logic [nvmeqp_pkg::CID_W-1:0]        s_cqe_command_id,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_out_kind,
    output logic [1:0]                          m_opcode,
    output logic [nvmeqp_pkg::CID_W-1:0]        m_command_id,
    output logic [nvmeqp_pkg::LBA_W-1:0]        m_cmd_slba,
    output logic [nvmeqp_pkg::NLB_W-1:0]        m_cmd_nlb,
    output logic                                m_prp2_used,
    output logic [nvmeqp_pkg::QIDX_W-1:0]       m_sq_tail_doorbell,
    output logic [nvmeqp_pkg::QIDX_W-1:0]       m_cq_head_doorbell,
    output logic [2:0]                          m_error_code,
    output logic [nvmeqp_pkg::STATUS_W-1:0]     m_device_status
);

    // The namespace id reaches no result field, so its writes are dropped.

    logic [4:0]                          bs_log2_reg;
    logic [nvmeqp_pkg::QIDX_W-1:0]       sub_tail_reg, sub_tail_next;
    logic [nvmeqp_pkg::QIDX_W-1:0]       comp_head_reg, comp_head_next;
    logic                                phase_reg, phase_next;
    logic [nvmeqp_pkg::CID_W-1:0]        next_id_reg, next_id_next;
    logic [nvmeqp_pkg::CID_W-1:0]        pending_id_reg, pending_id_next;
    logic                                busy_reg, busy_next;
    logic [nvmeqp_pkg::COUNT_W-1:0]      blocks_left_reg, blocks_left_next;
    logic [nvmeqp_pkg::LBA_W-1:0]        next_lba_reg, next_lba_next;
    logic                                write_mode_reg, write_mode_next;

    logic                                m_valid_reg, m_valid_next;
    logic                                m_kind_reg;
    logic [1:0]                          m_opcode_reg;
    logic [nvmeqp_pkg::CID_W-1:0]        m_cid_reg;
    logic [nvmeqp_pkg::LBA_W-1:0]        m_slba_reg;
    logic [nvmeqp_pkg::NLB_W-1:0]        m_nlb_reg;
    logic                                m_prp2_reg;
    logic [nvmeqp_pkg::QIDX_W-1:0]       m_tail_reg;
    logic [nvmeqp_pkg::QIDX_W-1:0]       m_head_reg;
    logic [2:0]                          m_err_reg;
    logic [nvmeqp_pkg::STATUS_W-1:0]     m_status_reg;

    logic                                res_valid;
    logic                                res_kind;
    logic [1:0]                          res_opcode;
    logic [nvmeqp_pkg::CID_W-1:0]        res_cid;
    logic [nvmeqp_pkg::LBA_W-1:0]        res_slba;
    logic [nvmeqp_pkg::NLB_W-1:0]        res_nlb;
    logic                                res_prp2;
    logic [2:0]                          res_err;
    logic [nvmeqp_pkg::STATUS_W-1:0]     res_status;

    logic                                accept;
    logic [4:0]                          eff_log2;
    logic [nvmeqp_pkg::CHUNK_W-1:0]      chunk_lim;
    logic [nvmeqp_pkg::CHUNK_W-1:0]      page_lim;
    logic                                too_large;
    logic [nvmeqp_pkg::QIDX_W-1:0]       tail_inc;
    logic [nvmeqp_pkg::QIDX_W-1:0]       head_inc;

    logic                                chunk_go;
    logic [nvmeqp_pkg::COUNT_W-1:0]      chunk_left;
    logic [nvmeqp_pkg::LBA_W-1:0]        chunk_lba;
    logic                                chunk_wm;
    logic [nvmeqp_pkg::CID_W-1:0]        fin_cid;
    logic [nvmeqp_pkg::CHUNK_W-1:0]      chunk_n;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign eff_log2 = (bs_log2_reg < nvmeqp_pkg::BS_LOG2_MIN ||
                       bs_log2_reg > nvmeqp_pkg::BS_LOG2_MAX) ?
                      nvmeqp_pkg::BS_LOG2_MIN : bs_log2_reg;

    // Blocks per chunk and per page; a zero chunk limit means one block
    // already exceeds two pages.
    assign chunk_lim = nvmeqp_pkg::CHUNK_W'(nvmeqp_pkg::CHUNK_BYTES) >> eff_log2;
    assign page_lim  = nvmeqp_pkg::CHUNK_W'(nvmeqp_pkg::PAGE_BYTES) >> eff_log2;
    assign too_large = (chunk_lim == '0);

    assign tail_inc = (sub_tail_reg == nvmeqp_pkg::QIDX_W'(nvmeqp_pkg::QUEUE_DEPTH - 1)) ?
                      '0 : sub_tail_reg + 1'b1;
    assign head_inc = (comp_head_reg == nvmeqp_pkg::QIDX_W'(nvmeqp_pkg::QUEUE_DEPTH - 1)) ?
                      '0 : comp_head_reg + 1'b1;

    assign chunk_n = (chunk_left < nvmeqp_pkg::COUNT_W'(chunk_lim)) ?
                     chunk_left[nvmeqp_pkg::CHUNK_W-1:0] : chunk_lim;

    always_comb begin
        sub_tail_next    = sub_tail_reg;
        comp_head_next   = comp_head_reg;
        phase_next       = phase_reg;
        next_id_next     = next_id_reg;
        pending_id_next  = pending_id_reg;
        busy_next        = busy_reg;
        blocks_left_next = blocks_left_reg;
        next_lba_next    = next_lba_reg;
        write_mode_next  = write_mode_reg;

        res_valid  = 1'b0;
        res_kind   = nvmeqp_pkg::KIND_CMD;
        res_opcode = nvmeqp_pkg::OPC_FLUSH;
        res_cid    = '0;
        res_slba   = '0;
        res_nlb    = '0;
        res_prp2   = 1'b0;
        res_err    = nvmeqp_pkg::ERR_OK;
        res_status = '0;

        chunk_go   = 1'b0;
        chunk_left = blocks_left_reg;
        chunk_lba  = next_lba_reg;
        chunk_wm   = write_mode_reg;
        fin_cid    = pending_id_reg;

        case (s_req_type)
            nvmeqp_pkg::REQ_RW: begin
                if (busy_reg) begin
                    res_valid = 1'b1;
                    res_kind  = nvmeqp_pkg::KIND_DONE;
                    res_err   = nvmeqp_pkg::ERR_BUSY;
                end else if (s_block_count == '0) begin
                    res_valid = 1'b1;
                    res_kind  = nvmeqp_pkg::KIND_DONE;
                    res_err   = nvmeqp_pkg::ERR_ZERO;
                end else begin
                    write_mode_next  = s_write_op;
                    next_lba_next    = s_start_lba;
                    blocks_left_next = s_block_count;
                    chunk_go         = 1'b1;
                    chunk_left       = s_block_count;
                    chunk_lba        = s_start_lba;
                    chunk_wm         = s_write_op;
                    fin_cid          = '0;
                end
            end
            nvmeqp_pkg::REQ_FLUSH: begin
                res_valid = 1'b1;
                if (busy_reg) begin
                    res_kind = nvmeqp_pkg::KIND_DONE;
                    res_err  = nvmeqp_pkg::ERR_BUSY;
                end else begin
                    res_cid          = next_id_reg;
                    next_id_next     = next_id_reg + 1'b1;
                    pending_id_next  = next_id_reg;
                    sub_tail_next    = tail_inc;
                    busy_next        = 1'b1;
                    blocks_left_next = '0;
                end
            end
            nvmeqp_pkg::REQ_CQE: begin
                if (busy_reg && s_cqe_phase == phase_reg) begin
                    comp_head_next = head_inc;
                    if (head_inc == '0) begin
                        phase_next = !phase_reg;
                    end
                    if (s_cqe_command_id != pending_id_reg) begin
                        res_valid        = 1'b1;
                        res_kind         = nvmeqp_pkg::KIND_DONE;
                        res_cid          = pending_id_reg;
                        res_err          = nvmeqp_pkg::ERR_ID;
                        busy_next        = 1'b0;
                        blocks_left_next = '0;
                    end else if (s_cqe_status_field != '0) begin
                        res_valid        = 1'b1;
                        res_kind         = nvmeqp_pkg::KIND_DONE;
                        res_cid          = pending_id_reg;
                        res_err          = nvmeqp_pkg::ERR_DEVICE;
                        res_status       = s_cqe_status_field;
                        busy_next        = 1'b0;
                        blocks_left_next = '0;
                    end else if (blocks_left_reg == '0) begin
                        res_valid = 1'b1;
                        res_kind  = nvmeqp_pkg::KIND_DONE;
                        res_cid   = pending_id_reg;
                        busy_next = 1'b0;
                    end else begin
                        chunk_go = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase

        if (chunk_go) begin
            res_valid = 1'b1;
            if (too_large) begin
                res_kind         = nvmeqp_pkg::KIND_DONE;
                res_cid          = fin_cid;
                res_err          = nvmeqp_pkg::ERR_TOO_LARGE;
                busy_next        = 1'b0;
                blocks_left_next = '0;
            end else begin
                res_opcode       = chunk_wm ? nvmeqp_pkg::OPC_WRITE : nvmeqp_pkg::OPC_READ;
                res_cid          = next_id_reg;
                res_slba         = chunk_lba;
                res_nlb          = nvmeqp_pkg::NLB_W'(chunk_n - 1'b1);
                res_prp2         = (chunk_n > page_lim);
                next_id_next     = next_id_reg + 1'b1;
                pending_id_next  = next_id_reg;
                sub_tail_next    = tail_inc;
                blocks_left_next = chunk_left - nvmeqp_pkg::COUNT_W'(chunk_n);
                next_lba_next    = chunk_lba + nvmeqp_pkg::LBA_W'(chunk_n);
                busy_next        = 1'b1;
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = res_valid;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bs_log2_reg <= nvmeqp_pkg::BS_LOG2_RESET;
        end else if (cfg_wr_en && cfg_addr == nvmeqp_pkg::CFG_BLOCK_SIZE_LOG2) begin
            bs_log2_reg <= cfg_wdata[4:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sub_tail_reg    <= '0;
            comp_head_reg   <= '0;
            phase_reg       <= 1'b1;
            next_id_reg     <= nvmeqp_pkg::CID_W'(1);
            pending_id_reg  <= '0;
            busy_reg        <= 1'b0;
            blocks_left_reg <= '0;
            next_lba_reg    <= '0;
            write_mode_reg  <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (accept) begin
                sub_tail_reg    <= sub_tail_next;
                comp_head_reg   <= comp_head_next;
                phase_reg       <= phase_next;
                next_id_reg     <= next_id_next;
                pending_id_reg  <= pending_id_next;
                busy_reg        <= busy_next;
                blocks_left_reg <= blocks_left_next;
                next_lba_reg    <= next_lba_next;
                write_mode_reg  <= write_mode_next;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && res_valid) begin
            m_kind_reg   <= res_kind;
            m_opcode_reg <= res_opcode;
            m_cid_reg    <= res_cid;
            m_slba_reg   <= res_slba;
            m_nlb_reg    <= res_nlb;
            m_prp2_reg   <= res_prp2;
            m_tail_reg   <= sub_tail_next;
            m_head_reg   <= comp_head_next;
            m_err_reg    <= res_err;
            m_status_reg <= res_status;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_out_kind         = m_kind_reg;
    assign m_opcode           = m_opcode_reg;
    assign m_command_id       = m_cid_reg;
    assign m_cmd_slba         = m_slba_reg;
    assign m_cmd_nlb          = m_nlb_reg;
    assign m_prp2_used        = m_prp2_reg;
    assign m_sq_tail_doorbell = m_tail_reg;
    assign m_cq_head_doorbell = m_head_reg;
    assign m_error_code       = m_err_reg;
    assign m_device_status    = m_status_reg;

    a_cmd_sets_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && res_valid && res_kind == nvmeqp_pkg::KIND_CMD |=> busy_reg)
        else $error("issued command did not leave the engine busy");

    a_cmd_id_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && res_valid && res_kind == nvmeqp_pkg::KIND_CMD |=>
        pending_id_reg == m_command_id)
        else $error("pending id differs from issued command id");

    a_done_clears_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && res_valid && res_kind == nvmeqp_pkg::KIND_DONE &&
        res_err != nvmeqp_pkg::ERR_BUSY && res_err != nvmeqp_pkg::ERR_ZERO |=> !busy_reg)
        else $error("finished request left the engine busy");

    a_busy_falls_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && $fell(busy_reg) |-> $past(accept) && $past(res_valid))
        else $error("busy cleared without a finished word");

endmodule
